[sv/rcs_pkg.sv]
package rcs_pkg;

    localparam int MaxFeatures = 1024;
    localparam int CountW      = 11;
    localparam int DotW        = 42;
    localparam int EnergyW     = 41;
    localparam int RowW        = 16;
    localparam int MetricW     = 18;
    localparam int ProdW       = 82;
    localparam int RootW       = 113;
    localparam int HalfW       = 21;
    localparam int OneQ15      = 32768;

    localparam logic CfgOutputMode = 1'b0;
    localparam logic CfgMinNormSq  = 1'b1;

    typedef struct packed {
        logic signed [DotW-1:0]    dot;
        logic [EnergyW-1:0]        xx;
        logic [EnergyW-1:0]        yy;
        logic                      zero;
        logic [RowW-1:0]           row;
    } row_sum_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } queue_ctrl_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_ROOT,
        BK_DONE
    } back_state_t;

endpackage

[sv/rcs_front.sv]
module rcs_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [15:0]                   x_elem,
    input  logic signed [15:0]                   y_elem,
    input  logic                                 last_elem,
    input  logic [rcs_pkg::EnergyW-1:0]          min_norm_sq,
    input  logic                                 q_full,
    output logic                                 push,
    output rcs_pkg::row_sum_t                    push_data
);

    logic signed [rcs_pkg::DotW-1:0]   dot_reg, dot_next;
    logic [rcs_pkg::EnergyW-1:0]       xx_reg, xx_next;
    logic [rcs_pkg::EnergyW-1:0]       yy_reg, yy_next;
    logic [rcs_pkg::CountW-1:0]        cnt_reg;
    logic [rcs_pkg::RowW-1:0]          row_reg;
    logic signed [31:0]                pxy;
    logic signed [31:0]                pxx;
    logic signed [31:0]                pyy;
    logic                              accept;
    logic                              take;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign take     = cnt_reg < rcs_pkg::CountW'(rcs_pkg::MaxFeatures);

    assign pxy = x_elem * y_elem;
    assign pxx = x_elem * x_elem;
    assign pyy = y_elem * y_elem;

    always_comb
    begin
        dot_next = dot_reg;
        xx_next  = xx_reg;
        yy_next  = yy_reg;
        if (take)
        begin
            dot_next = dot_reg + $signed({{(rcs_pkg::DotW-32){pxy[31]}}, pxy});
            xx_next  = xx_reg + {{(rcs_pkg::EnergyW-32){1'b0}}, pxx[31:0]};
            yy_next  = yy_reg + {{(rcs_pkg::EnergyW-32){1'b0}}, pyy[31:0]};
        end
    end

    assign push           = accept && last_elem;
    assign push_data.dot  = dot_next;
    assign push_data.xx   = xx_next;
    assign push_data.yy   = yy_next;
    assign push_data.zero = (xx_next <= min_norm_sq) || (yy_next <= min_norm_sq);
    assign push_data.row  = row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            xx_reg  <= '0;
            yy_reg  <= '0;
            cnt_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (last_elem)
            begin
                dot_reg <= '0;
                xx_reg  <= '0;
                yy_reg  <= '0;
                cnt_reg <= '0;
                row_reg <= row_reg + 1'b1;
            end
            else
            begin
                dot_reg <= dot_next;
                xx_reg  <= xx_next;
                yy_reg  <= yy_next;
                if (take)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

endmodule

[sv/rcs_queue.sv]
module rcs_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rcs_pkg::row_sum_t     push_data,
    input  logic                  pop,
    output logic                  full,
    output logic                  empty,
    output rcs_pkg::row_sum_t     head
);

    rcs_pkg::row_sum_t mem [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[sv/rcs_back.sv]
module rcs_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  rcs_pkg::row_sum_t                      head,
    input  logic                                   q_empty,
    output logic                                   pop,
    input  logic                                   output_mode,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [rcs_pkg::MetricW-1:0]     metric_value,
    output logic                                   zero_norm,
    output logic [rcs_pkg::RowW-1:0]               row_index
);

    rcs_pkg::back_state_t                  state_reg, state_next;
    rcs_pkg::row_sum_t                     ent_reg;
    logic [3:0]                            cnt_reg;
    logic [rcs_pkg::ProdW-1:0]             p_reg;
    logic [rcs_pkg::ProdW-1:0]             d_reg;
    logic [rcs_pkg::RootW-1:0]             r_reg;
    logic [rcs_pkg::RootW-1:0]             pb_reg;
    logic [rcs_pkg::RootW-1:0]             qp_reg;
    logic [15:0]                           q_reg;
    logic                                  out_valid_reg;
    logic signed [rcs_pkg::MetricW-1:0]    metric_reg;
    logic                                  zero_reg;
    logic [rcs_pkg::RowW-1:0]              row_reg;

    logic [rcs_pkg::EnergyW-1:0]           mag;
    logic [rcs_pkg::EnergyW-1:0]           src_a;
    logic [rcs_pkg::EnergyW-1:0]           src_b;
    logic [rcs_pkg::HalfW-1:0]             a_part;
    logic [rcs_pkg::HalfW-1:0]             b_part;
    logic [2*rcs_pkg::HalfW-1:0]           pp;
    logic [rcs_pkg::ProdW-1:0]             pp_sh;
    logic [rcs_pkg::ProdW-1:0]             d_fin;
    logic [rcs_pkg::RootW:0]               trial;
    logic                                  fit;
    logic [rcs_pkg::RootW-1:0]             qp_upd;
    logic signed [rcs_pkg::MetricW-1:0]    sim;
    logic signed [rcs_pkg::MetricW-1:0]    metric_calc;
    logic                                  load_out;

    // Magnitude of the dot product; at most 2^40 so it fits 41 bits.
    assign mag = rcs_pkg::EnergyW'(ent_reg.dot[rcs_pkg::DotW-1] ? -ent_reg.dot : ent_reg.dot);

    // Four 21x21 partial products for xx*yy, then four for mag*mag.
    assign src_a  = cnt_reg[2] ? mag : ent_reg.xx;
    assign src_b  = cnt_reg[2] ? mag : ent_reg.yy;
    assign a_part = cnt_reg[1] ? {1'b0, src_a[rcs_pkg::EnergyW-1:rcs_pkg::HalfW]}
                               : src_a[rcs_pkg::HalfW-1:0];
    assign b_part = cnt_reg[0] ? {1'b0, src_b[rcs_pkg::EnergyW-1:rcs_pkg::HalfW]}
                               : src_b[rcs_pkg::HalfW-1:0];
    assign pp     = a_part * b_part;

    always_comb
    begin
        unique case ({cnt_reg[1], cnt_reg[0]})
            2'b00:   pp_sh = rcs_pkg::ProdW'(pp);
            2'b01,
            2'b10:   pp_sh = rcs_pkg::ProdW'(pp) << rcs_pkg::HalfW;
            default: pp_sh = rcs_pkg::ProdW'(pp) << (2 * rcs_pkg::HalfW);
        endcase
    end

    assign d_fin = d_reg + pp_sh;

    // One quotient bit per step: remainder against the next trial term.
    assign trial  = {1'b0, qp_reg} + {1'b0, pb_reg};
    assign fit    = trial <= {1'b0, r_reg};
    assign qp_upd = fit ? qp_reg + (pb_reg << 1) : qp_reg;

    assign sim         = ent_reg.dot[rcs_pkg::DotW-1] ? -$signed({2'b00, q_reg})
                                                      : $signed({2'b00, q_reg});
    assign metric_calc = output_mode ? rcs_pkg::MetricW'(rcs_pkg::OneQ15) - sim : sim;

    assign load_out = (state_reg == rcs_pkg::BK_DONE) && (!out_valid_reg || out_ready);
    assign pop      = (state_reg == rcs_pkg::BK_IDLE) && !q_empty;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rcs_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = head.zero ? rcs_pkg::BK_DONE : rcs_pkg::BK_MUL;
                end
            end
            rcs_pkg::BK_MUL:
            begin
                if (cnt_reg == 4'd7)
                begin
                    state_next = rcs_pkg::BK_ROOT;
                end
            end
            rcs_pkg::BK_ROOT:
            begin
                if (cnt_reg == 4'd0)
                begin
                    state_next = rcs_pkg::BK_DONE;
                end
            end
            rcs_pkg::BK_DONE:
            begin
                if (load_out)
                begin
                    state_next = rcs_pkg::BK_IDLE;
                end
            end
            default: state_next = rcs_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcs_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            rcs_pkg::BK_IDLE:
            begin
                ent_reg <= head;
                cnt_reg <= 4'd0;
                p_reg   <= '0;
                d_reg   <= '0;
                q_reg   <= '0;
            end
            rcs_pkg::BK_MUL:
            begin
                if (!cnt_reg[2])
                begin
                    p_reg <= p_reg + pp_sh;
                end
                else
                begin
                    d_reg <= d_fin;
                end
                if (cnt_reg == 4'd7)
                begin
                    r_reg   <= rcs_pkg::RootW'(d_fin) << 30;
                    pb_reg  <= rcs_pkg::RootW'(p_reg) << 30;
                    qp_reg  <= '0;
                    cnt_reg <= 4'd15;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            rcs_pkg::BK_ROOT:
            begin
                if (fit)
                begin
                    r_reg          <= r_reg - trial[rcs_pkg::RootW-1:0];
                    q_reg[cnt_reg] <= 1'b1;
                end
                qp_reg  <= qp_upd >> 1;
                pb_reg  <= pb_reg >> 2;
                cnt_reg <= cnt_reg - 1'b1;
            end
            rcs_pkg::BK_DONE:
            begin
                if (load_out)
                begin
                    metric_reg <= metric_calc;
                    zero_reg   <= ent_reg.zero;
                    row_reg    <= ent_reg.row;
                end
            end
            default:
            begin
                cnt_reg <= 4'd0;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign metric_value = metric_reg;
    assign zero_norm    = zero_reg;
    assign row_index    = row_reg;

    a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rcs_pkg::BK_MUL |-> cnt_reg <= 4'd7)
        else $error("multiply phase counter out of range");

    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && !ent_reg.zero |-> q_reg <= 16'(rcs_pkg::OneQ15))
        else $error("similarity magnitude above one");

    a_zero_skip: assert property (@(posedge clk) disable iff (!rst_n)
        pop && head.zero |=> state_reg == rcs_pkg::BK_DONE)
        else $error("zero-norm row entered arithmetic");

    a_zero_q: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && ent_reg.zero |-> q_reg == 16'd0)
        else $error("zero-norm row carries a quotient");

endmodule

[sv/row_cosine_similarity.sv]
// Row cosine similarity engine.
//
// The input channel (in_valid/in_ready) carries one transfer per element pair:
// x_elem and y_elem in signed Q1.15, and last_elem on the final pair of a row.
// Element pairs are taken one per cycle while in_ready is high; the front end
// multiplies and adds them into the dot product and the two squared norms.
// Past 1024 elements further pairs are ignored, though a last element still
// closes the row. On the last element the row sums are pushed into a
// two-entry queue. The back end turns each row into one result transfer on
// the output channel (out_valid/out_ready): metric_value in units of 2^-15,
// zero_norm and row_index. It forms 21x21 partial products for xx*yy and
// dot*dot, then runs a bit-per-step exact root-of-ratio search; the back
// end takes a new row from the queue only after the previous result is
// loaded into the output register. A zero-norm row skips the math.
// When the receiver stalls, the result holds in the output register, the
// queue fills, and in_ready drops only when both queue entries are taken.
// Reset clears the front-end accumulators and counters, the queue and the
// configuration (similarity mode, threshold zero). Configuration is written
// through cfg_we/cfg_index/cfg_data while the engine is idle.
module row_cosine_similarity (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [15:0]                     x_elem,
    input  logic signed [15:0]                     y_elem,
    input  logic                                   last_elem,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [rcs_pkg::MetricW-1:0]     metric_value,
    output logic                                   zero_norm,
    output logic [rcs_pkg::RowW-1:0]               row_index,
    input  logic                                   cfg_we,
    input  logic                                   cfg_index,
    input  logic [rcs_pkg::EnergyW-1:0]            cfg_data
);

    logic                           mode_reg;
    logic [rcs_pkg::EnergyW-1:0]    min_reg;
    rcs_pkg::queue_ctrl_t           qc;
    rcs_pkg::row_sum_t              push_data;
    rcs_pkg::row_sum_t              head;

    // Config regs; user writes only while the engine is idle (unenforced).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            min_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rcs_pkg::CfgOutputMode: mode_reg <= cfg_data[0];
                rcs_pkg::CfgMinNormSq:  min_reg  <= cfg_data;
                default:                mode_reg <= mode_reg;
            endcase
        end
    end

    rcs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .x_elem      (x_elem),
        .y_elem      (y_elem),
        .last_elem   (last_elem),
        .min_norm_sq (min_reg),
        .q_full      (qc.full),
        .push        (qc.push),
        .push_data   (push_data)
    );

    rcs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (qc.push),
        .push_data (push_data),
        .pop       (qc.pop),
        .full      (qc.full),
        .empty     (qc.empty),
        .head      (head)
    );

    rcs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_empty      (qc.empty),
        .pop          (qc.pop),
        .output_mode  (mode_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .metric_value (metric_value),
        .zero_norm    (zero_norm),
        .row_index    (row_index)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

// Self-checking testbench for row_cosine_similarity.
// Element pairs are queued by the stimulus block and sent by a driver that
// idles at random between transfers. A monitor stalls the result channel at
// random and checks each result transfer against the result predicted
// when the closing element of the row was accepted.
module testbench;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
    } elem_pair_t;

    typedef struct {
        logic signed [rcs_pkg::MetricW-1:0] metric;
        logic                               zero;
        logic [rcs_pkg::RowW-1:0]           row;
    } row_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] x_elem = '0;
    logic signed [15:0] y_elem = '0;
    logic last_elem = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [rcs_pkg::MetricW-1:0] metric_value;
    logic zero_norm;
    logic [rcs_pkg::RowW-1:0] row_index;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [rcs_pkg::EnergyW-1:0] cfg_data = '0;

    row_cosine_similarity uut (.*);

    always #2 clk = ~clk;

    // Predictor state, a private copy of the block's accumulators and setup.
    logic                            mode_distance;
    logic [rcs_pkg::EnergyW-1:0]     norm_floor;
    logic signed [rcs_pkg::DotW-1:0] dot_sum;
    logic [rcs_pkg::EnergyW-1:0]     x_norm_sq;
    logic [rcs_pkg::EnergyW-1:0]     y_norm_sq;
    int unsigned                     pair_count;
    logic [rcs_pkg::RowW-1:0]        rows_done;

    elem_pair_t  pending_pairs[$];
    row_result_t expected_results[$];
    int  mismatches = 0;
    int  results_seen = 0;
    int  zero_rows = 0;
    longint cycles = 0;

    // Handshakes sampled at the rising edge for the next falling-edge decision.
    logic in_ready_s = 1'b0;
    logic out_valid_s = 1'b0;

    // Largest q in [0, 32768] with q*q*xx*yy <= dot*dot*2^30, by bisection
    // over exact 160-bit products.
    function automatic logic [15+1:0] root_of_ratio(logic [rcs_pkg::DotW-1:0] mag,
            logic [rcs_pkg::EnergyW-1:0] xx, logic [rcs_pkg::EnergyW-1:0] yy);
        logic [159:0] num;
        logic [159:0] den;
        logic [159:0] trial;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        num = ({118'd0, mag} * {118'd0, mag}) << 30;
        den = {119'd0, xx} * {119'd0, yy};
        lo = 0;
        hi = rcs_pkg::OneQ15;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            trial = den * 160'(mid) * 160'(mid);
            if (trial <= num)
                lo = mid;
            else
                hi = mid - 1;
        end
        return 17'(lo);
    endfunction

    // Called for every accepted element pair; a closing pair yields a result.
    task automatic accumulate_pair(elem_pair_t p);
        row_result_t r;
        logic signed [rcs_pkg::MetricW-1:0] sim;
        logic [rcs_pkg::DotW-1:0] mag;
        if (pair_count < rcs_pkg::MaxFeatures)
        begin
            dot_sum   = dot_sum + rcs_pkg::DotW'(int'(p.x) * int'(p.y));
            x_norm_sq = x_norm_sq + rcs_pkg::EnergyW'(int'(p.x) * int'(p.x));
            y_norm_sq = y_norm_sq + rcs_pkg::EnergyW'(int'(p.y) * int'(p.y));
            pair_count++;
        end
        if (p.last)
        begin
            sim = '0;
            r.zero = (x_norm_sq <= norm_floor) || (y_norm_sq <= norm_floor);
            if (!r.zero)
            begin
                mag = dot_sum < 0 ? -dot_sum : dot_sum;
                sim = rcs_pkg::MetricW'(root_of_ratio(mag, x_norm_sq, y_norm_sq));
                if (dot_sum < 0)
                    sim = -sim;
            end
            r.metric = mode_distance ? rcs_pkg::MetricW'(rcs_pkg::OneQ15) - sim : sim;
            r.row = rows_done;
            expected_results.push_back(r);
            rows_done++;
            dot_sum = '0;
            x_norm_sq = '0;
            y_norm_sq = '0;
            pair_count = 0;
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        mismatches++;
    endtask

    // Driver: one transfer per accepted pair, with a random idle gap drawn
    // for each item. Valid is only lowered when no item follows at once.
    int in_gap = 0;
    always @(negedge clk)
    begin
        elem_pair_t p;
        if (rst_n)
        begin
            if (in_valid && in_ready_s)
            begin
                in_gap = $urandom_range(0, 3);
                if ($urandom_range(0, 3) == 0)
                    in_gap = 0;
            end
            if (!in_valid || in_ready_s)
            begin
                if (in_gap > 0 || pending_pairs.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (in_gap > 0)
                        in_gap--;
                end
                else
                begin
                    p = pending_pairs.pop_front();
                    in_valid  <= 1'b1;
                    x_elem    <= p.x;
                    y_elem    <= p.y;
                    last_elem <= p.last;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        elem_pair_t p;
        cycles++;
        in_ready_s <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            p.x = x_elem;
            p.y = y_elem;
            p.last = last_elem;
            accumulate_pair(p);
        end
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                report_mismatch("unexpected result, row", row_index, -1);
            else
            begin
                row_result_t e;
                e = expected_results.pop_front();
                if (metric_value !== e.metric)
                    report_mismatch("metric_value", metric_value, e.metric);
                if (zero_norm !== e.zero)
                    report_mismatch("zero_norm", zero_norm, e.zero);
                if (row_index !== e.row)
                    report_mismatch("row_index", row_index, e.row);
                if (e.zero)
                    zero_rows++;
            end
        end
    end

    // Monitor side back-pressure: a random stall drawn per result.
    int out_gap = 0;
    always @(negedge clk)
    begin
        if (out_ready && out_valid_s)
            out_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
        if (out_gap > 0)
        begin
            out_ready <= 1'b0;
            out_gap--;
        end
        else
            out_ready <= 1'b1;
    end
    always @(posedge clk)
        out_valid_s <= out_valid && out_ready;

    // Watchdog: far above the slowest legal run.
    always @(posedge clk)
    begin
        if (cycles > 2000000)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic signed [15:0] pick_elem();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_pair(logic signed [15:0] x, logic signed [15:0] y, logic last);
        elem_pair_t p;
        p.x = x;
        p.y = y;
        p.last = last;
        pending_pairs.push_back(p);
    endtask

    // Random row of the given length; the flavor ties y to x, sets it to zero, or makes it free.
    task automatic add_random_row(int len, int flavor);
        logic signed [15:0] x;
        logic signed [15:0] y;
        for (int i = 0; i < len; i++)
        begin
            x = pick_elem();
            case (flavor)
                0: y = x;
                1: y = -x;
                2: y = 16'sd0;
                default: y = pick_elem();
            endcase
            add_pair(x, y, i == len - 1);
        end
    endtask

    // Waits until the queue is drained, every result is in, and the back end
    // has had time to finish; configuration is written only then.
    task automatic drain_and_settle();
        while (pending_pairs.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [rcs_pkg::EnergyW-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == rcs_pkg::CfgOutputMode)
            mode_distance = val[0];
        else
            norm_floor = val;
    endtask

    logic [rcs_pkg::EnergyW-1:0] floors[4];
    initial
    begin
        mode_distance = 1'b0;
        norm_floor = '0;
        dot_sum = '0;
        x_norm_sq = '0;
        y_norm_sq = '0;
        pair_count = 0;
        rows_done = '0;
        floors[0] = '0;
        floors[1] = 41'd1 << 30;
        floors[2] = 41'd1 << 40;
        floors[3] = 41'd12345;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows: extremes, opposite and orthogonal rows, a zero row,
        // a row that closes on its first element, and one saturated row.
        add_pair(16'sh7fff, 16'sh7fff, 1'b1);
        add_pair(16'sh8000, 16'sh7fff, 1'b1);
        add_pair(16'sh8000, 16'sh8000, 1'b1);
        add_pair(16'sh0000, 16'sh0000, 1'b1);
        add_pair(16'sh4000, 16'sh0000, 1'b0);
        add_pair(16'sh0000, 16'sh4000, 1'b1);
        add_pair(16'sh0001, 16'shffff, 1'b0);
        add_pair(16'sh0003, 16'sh0002, 1'b1);
        add_pair(16'shffff, 16'sh5555, 1'b0);
        add_pair(16'shaaaa, 16'sh0001, 1'b1);
        for (int i = 0; i < 1030; i++)
            add_pair(16'sh7fff, (i >= 1024) ? 16'sh8000 : 16'sh1234, i == 1029);
        drain_and_settle();

        // Distance mode with the zero row and extremes again.
        write_reg(rcs_pkg::CfgOutputMode, 41'd1);
        add_pair(16'sh0000, 16'sh0000, 1'b1);
        add_pair(16'sh7fff, 16'sh8000, 1'b1);
        add_pair(16'sh7fff, 16'sh7fff, 1'b1);
        drain_and_settle();

        // Random phases of short rows, each with its own mode and norm floor.
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(rcs_pkg::CfgOutputMode, 41'($urandom_range(0, 1)));
            write_reg(rcs_pkg::CfgMinNormSq, (ph == 7) ? 41'h1ffffffffff : floors[ph % 4]);
            for (int n = 0; n < 25; n++)
                add_random_row($urandom_range(1, 8), $urandom_range(0, 5));
            drain_and_settle();
        end

        $display("%0d results checked over %0d rows, %0d of them zero-norm rows",
                 results_seen, rows_done, zero_rows);
        $display("both output modes and thresholds from zero to full scale were used");
        if (mismatches == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
